// ----- hdl/pgi_pkg.sv -----
// ----------------------------------------------------------------------------
// pgi_pkg
// Shared types and constants for the palette gradient interpolator.
// ----------------------------------------------------------------------------
package pgi_pkg;

  localparam int PALETTE_ENTRIES = 16;
  localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
  localparam int COLOR_W         = 15;
  localparam int LINE_W          = 8;
  localparam int STEP_W          = 4;

  // Screen layout of the gradient
  localparam logic [LINE_W-1:0] HEAD_LINES = 8'd5;
  localparam logic [LINE_W-1:0] TAIL_START = 8'd155;
  localparam logic [ADDR_W-1:0] LAST_ENTRY = 4'd15;

  // Item opcodes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [ADDR_W-1:0]   entry_index;
    logic [COLOR_W-1:0]  color_value;
    logic [LINE_W-1:0]   line_number;
  } req_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0]  line_color;
    logic [LINE_W-1:0]   line_echo;
  } rsp_item_t;

  // Write and read requests into the palette store
  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [COLOR_W-1:0]  data;
  } pal_wr_t;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr_a;
    logic [ADDR_W-1:0]   addr_b;
  } pal_rd_t;

endpackage

// ----- hdl/pgi_palette_ram.sv -----
// ----------------------------------------------------------------------------
// pgi_palette_ram
// Palette color store: one write port, two registered read ports. Entries
// never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module pgi_palette_ram (
  input  logic                      clk,
  input  logic                      rst,
  input  pgi_pkg::pal_wr_t          wr,
  input  pgi_pkg::pal_rd_t          rd,
  output logic [pgi_pkg::COLOR_W-1:0] rd_data_a,
  output logic [pgi_pkg::COLOR_W-1:0] rd_data_b
);
  import pgi_pkg::*;

  logic [COLOR_W-1:0]         mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] entry_valid;

  // Store write data
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Track written entries; reset makes the whole store read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr.en) begin
      entry_valid[wr.addr] <= 1'b1;
    end
  end

  // Register both read ports; hold data between reads
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_a <= entry_valid[rd.addr_a] ? mem[rd.addr_a] : '0;
      rd_data_b <= entry_valid[rd.addr_b] ? mem[rd.addr_b] : '0;
    end
  end

endmodule

// ----- hdl/pgi_blend.sv -----
// ----------------------------------------------------------------------------
// pgi_blend
// Per-channel blend between two BGR555 colors at step j of ten, with
// truncation toward zero on each partial quotient.
// ----------------------------------------------------------------------------
module pgi_blend (
  input  logic [pgi_pkg::COLOR_W-1:0] base_color,
  input  logic [pgi_pkg::COLOR_W-1:0] next_color,
  input  logic [pgi_pkg::STEP_W-1:0]  step,
  output logic [pgi_pkg::COLOR_W-1:0] color
);
  import pgi_pkg::*;

  // Blend one 5-bit channel. Work on |d| and apply the sign at the end,
  // which matches truncation toward zero of every term.
  function automatic logic [4:0] blend_ch(input logic [4:0] b, input logic [4:0] n,
                                          input logic [3:0] j);
    logic        neg;
    logic [4:0]  mag;
    logic [12:0] q_prod;
    logic [1:0]  dq;
    logic [3:0]  dr;
    logic [6:0]  rj;
    logic [14:0] rj_prod;
    logic [3:0]  t1;
    logic [8:0]  dj;
    logic [13:0] dj_prod;
    logic [1:0]  t2;
    logic [4:0]  jq;
    logic [5:0]  m;
    logic [6:0]  v;
    neg     = (n < b);
    mag     = neg ? (b - n) : (n - b);
    // |d| / 10 and |d| % 10 by reciprocal multiply
    q_prod  = 13'(mag) * 13'd205;
    dq      = q_prod[12:11];
    dr      = 4'(mag - 5'(dq) * 5'd10);
    // (|d| % 10) * j / 10
    rj      = 7'(dr) * 7'(j);
    rj_prod = 15'(rj) * 15'd205;
    t1      = rj_prod[14:11];
    // |d| * j / 100
    dj      = 9'(mag) * 9'(j);
    dj_prod = 14'(dj) * 14'd41;
    t2      = dj_prod[13:12];
    jq      = 5'(j) * 5'(dq);
    m       = 6'(jq) + 6'(t1) + 6'(t2);
    v       = neg ? (7'(b) - 7'(m)) : (7'(b) + 7'(m));
    return v[4:0];
  endfunction

  // Blend red, green and blue independently
  always_comb begin
    color[4:0]   = blend_ch(base_color[4:0],   next_color[4:0],   step);
    color[9:5]   = blend_ch(base_color[9:5],   next_color[9:5],   step);
    color[14:10] = blend_ch(base_color[14:10], next_color[14:10], step);
  end

endmodule

// ----- hdl/palette_gradient_interpolator.sv -----
// ----------------------------------------------------------------------------
// palette_gradient_interpolator
// Palette store with per-line gradient lookup between adjacent entries.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one item per handshake.
//   A write item (mode 0) stores color_value at entry_index and returns
//   nothing. A read item (mode 1) returns one rsp item with the blended
//   color of line_number and the line number echoed back.
//   A read item passes the registered palette read and then the blend and
//   output register on its way to rsp. Throughput: one item per cycle
//   while the output is not stalled; the two-port palette read lets both
//   segment ends come out in the same cycle.
//   A write followed by a read in the next cycle sees the new color.
//   Reset clears the control pipeline and marks every palette entry as
//   unwritten, so all entries read as zero until written again.
//   When rsp_ready is low the result holds in the output register; one
//   more read item may sit in the read stage, after which req_ready drops.
// ----------------------------------------------------------------------------
module palette_gradient_interpolator (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  pgi_pkg::req_item_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output pgi_pkg::rsp_item_t rsp
);
  import pgi_pkg::*;

  logic                accept;
  logic                s1_valid;
  logic                s1_advance;
  logic [STEP_W-1:0]   s1_step;
  logic [LINE_W-1:0]   s1_line;

  logic [LINE_W-1:0]   k;
  logic [15:0]         seg_prod;
  logic [ADDR_W-1:0]   seg;
  logic [ADDR_W-1:0]   seg_sel;
  logic [STEP_W-1:0]   step_sel;

  pal_wr_t             wr;
  pal_rd_t             rd;
  logic [COLOR_W-1:0]  base_color;
  logic [COLOR_W-1:0]  next_color;
  logic [COLOR_W-1:0]  blend_color;

  // Handshake: take a new item when the read stage is empty or moving on
  assign s1_advance = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready  = !s1_valid || s1_advance;
  assign accept     = req_valid && req_ready;

  // Decode line into segment and step; head and tail lines use step zero
  always_comb begin
    k        = req.line_number - HEAD_LINES;
    seg_prod = 16'(k) * 16'd205;
    seg      = seg_prod[14:11];
    if (req.line_number < HEAD_LINES) begin
      seg_sel  = '0;
      step_sel = '0;
    end else if (req.line_number >= TAIL_START) begin
      seg_sel  = LAST_ENTRY;
      step_sel = '0;
    end else begin
      seg_sel  = seg;
      step_sel = 4'(k - 8'(seg) * 8'd10);
    end
  end

  // Drive palette write and read requests
  always_comb begin
    wr.en     = accept && (req.mode == MODE_WRITE);
    wr.addr   = req.entry_index;
    wr.data   = req.color_value;
    rd.en     = accept && (req.mode == MODE_READ);
    rd.addr_a = seg_sel;
    rd.addr_b = seg_sel + 4'd1;
  end

  pgi_palette_ram u_ram (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .rd        (rd),
    .rd_data_a (base_color),
    .rd_data_b (next_color)
  );

  // Read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (req.mode == MODE_READ);
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Read stage payload travels alongside the palette read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      s1_step <= step_sel;
      s1_line <= req.line_number;
    end
  end

  pgi_blend u_blend (
    .base_color (base_color),
    .next_color (next_color),
    .step       (s1_step),
    .color      (blend_color)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp.line_color <= blend_color;
      rsp.line_echo  <= s1_line;
    end
  end

`ifndef SYNTHESIS
  a_read_fills_stage: assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == MODE_READ) |=> s1_valid)
    else $error("read item did not enter read stage");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == MODE_WRITE) |=> !s1_valid)
    else $error("write item produced a pending result");

  a_stage_drains: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !rsp_valid) |=> rsp_valid)
    else $error("read stage did not move to output");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (s1_valid && rsp_valid && !rsp_ready))
    else $error("request stalled without a full pipeline");
`endif

endmodule

// ----- tb/palette_gradient_interpolator_test.sv -----
// ----------------------------------------------------------------------------
// palette_gradient_interpolator_test
// Self-checking bench for the palette gradient interpolator. Palette writes
// and line reads go in over the request channel. A local copy of the palette
// predicts every line color, and each response is matched in order against
// that prediction. Both sides insert random idle cycles. One phase holds
// the response side off so the block fills up and backs up its input.
// ----------------------------------------------------------------------------
module palette_gradient_interpolator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pgi_pkg::*;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_item_t rsp;

  // Local copy of the palette store and the line colors still owed
  logic [COLOR_W-1:0] palette_model [PALETTE_ENTRIES] = '{default: '0};
  rsp_item_t          pending_lines [$];
  int                 mismatch_count = 0;

  // Idling controls: no_idle for sender and receiver, rx_hold_cycles for the receiver
  bit no_idle         = 0;
  int rx_hold_cycles  = 0;

  palette_gradient_interpolator DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Blend two adjacent palette colors for one screen line
  function automatic logic [COLOR_W-1:0] blend_line(logic [LINE_W-1:0] line);
    int                 k;
    int                 seg;
    int                 step;
    int                 base;
    int                 nxt;
    int                 d;
    int                 v;
    logic [COLOR_W-1:0] lo;
    logic [COLOR_W-1:0] hi;
    logic [COLOR_W-1:0] mix;
    if (line < HEAD_LINES) begin
      return palette_model[0];
    end
    if (line >= TAIL_START) begin
      return palette_model[LAST_ENTRY];
    end
    k    = int'(line) - int'(HEAD_LINES);
    seg  = k / 10;
    step = k % 10;
    lo   = palette_model[seg];
    hi   = palette_model[seg + 1];
    for (int ch = 0; ch < 3; ch++) begin
      base = int'(lo[ch*5 +: 5]);
      nxt  = int'(hi[ch*5 +: 5]);
      d    = nxt - base;
      v    = base + step * (d / 10) + ((d % 10) * step) / 10 + (d * step) / 100;
      mix[ch*5 +: 5] = v[4:0];
    end
    return mix;
  endfunction

  function automatic req_item_t make_req(logic m, int idx, int color, int line);
    req_item_t it;
    it.mode        = m;
    it.entry_index = idx[ADDR_W-1:0];
    it.color_value = color[COLOR_W-1:0];
    it.line_number = line[LINE_W-1:0];
    return it;
  endfunction

  // Random item; ignored fields always carry random junk
  function automatic req_item_t random_item(int read_pct);
    req_item_t it;
    int        pick;
    it.mode        = ($urandom_range(0, 99) < read_pct) ? MODE_READ : MODE_WRITE;
    it.entry_index = ADDR_W'($urandom_range(0, PALETTE_ENTRIES - 1));
    pick           = $urandom_range(0, 7);
    if (pick == 0) begin
      it.color_value = '0;
    end else if (pick == 1) begin
      it.color_value = '1;
    end else begin
      it.color_value = COLOR_W'($urandom_range(0, 32767));
    end
    if ($urandom_range(0, 9) == 0) begin
      it.line_number = LINE_W'($urandom_range(160, 255));
    end else begin
      it.line_number = LINE_W'($urandom_range(0, 159));
    end
    return it;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(req_item_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  // Record accepted items and check each accepted result
  always @(posedge clk) begin : result_check
    rsp_item_t want;
    if (!rst) begin
      if (req_valid && req_ready) begin
        if (req.mode == MODE_WRITE) begin
          palette_model[req.entry_index] = req.color_value;
        end else begin
          want.line_color = blend_line(req.line_number);
          want.line_echo  = req.line_number;
          pending_lines.push_back(want);
        end
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_lines.size() == 0) begin
          $error("unexpected result: line_color %h line_echo %0d",
                 rsp.line_color, rsp.line_echo);
          mismatch_count++;
        end else begin
          want = pending_lines.pop_front();
          if (rsp.line_color !== want.line_color) begin
            $error("line_color: expected %h, got %h", want.line_color, rsp.line_color);
            mismatch_count++;
          end
          if (rsp.line_echo !== want.line_echo) begin
            $error("line_echo: expected %0d, got %0d", want.line_echo, rsp.line_echo);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Response side: random gaps per item, or a long hold when requested
  initial begin : result_sink
    int gap;
    rsp_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        gap            = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 5);
      end
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  task automatic test_reset_values();
    send_item(make_req(MODE_READ, 9, 32767, 0));
    send_item(make_req(MODE_READ, 0, 0, 159));
  endtask

  // Extreme colors, largest rising and falling deltas, head and tail line boundaries and segment edges
  task automatic test_line_boundaries();
    send_item(make_req(MODE_WRITE, 0, 32767, 255));
    send_item(make_req(MODE_WRITE, 1, 0, 0));
    send_item(make_req(MODE_WRITE, 2, 32767, 17));
    send_item(make_req(MODE_WRITE, 14, 0, 200));
    send_item(make_req(MODE_WRITE, 15, 32767, 3));
    send_item(make_req(MODE_READ, 15, 32767, 0));
    send_item(make_req(MODE_READ, 0, 0, 4));
    send_item(make_req(MODE_READ, 7, 12345, 5));
    send_item(make_req(MODE_READ, 0, 0, 9));
    send_item(make_req(MODE_READ, 0, 0, 14));
    send_item(make_req(MODE_READ, 0, 0, 15));
    send_item(make_req(MODE_READ, 0, 0, 24));
    send_item(make_req(MODE_READ, 0, 0, 154));
    send_item(make_req(MODE_READ, 0, 0, 155));
    send_item(make_req(MODE_READ, 0, 0, 159));
    send_item(make_req(MODE_READ, 0, 0, 160));
    send_item(make_req(MODE_READ, 15, 32767, 255));
  endtask

  // Write then read the same entry on consecutive cycles
  task automatic test_write_then_read();
    no_idle = 1;
    send_item(make_req(MODE_WRITE, 0, 16'h1234, 0));
    send_item(make_req(MODE_READ, 0, 0, 0));
    send_item(make_req(MODE_WRITE, 1, 16'h7C1F, 0));
    send_item(make_req(MODE_READ, 0, 0, 10));
    no_idle = 0;
  endtask

  // Hold off the response side so the block backs up its input
  task automatic test_output_stall();
    no_idle        = 1;
    rx_hold_cycles = 300;
    repeat (60) send_item(random_item(90));
    no_idle = 0;
  endtask

  task automatic test_random_mix(int count, bit burst);
    no_idle = burst;
    repeat (count) send_item(random_item(70));
    no_idle = 0;
  endtask

  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_line_boundaries();
    test_write_then_read();
    test_random_mix(700, 0);
    test_random_mix(200, 1);
    test_output_stall();
    test_random_mix(540, 0);

    // Drain outstanding results, then let the pipeline settle
    req_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
